// ===== hdl/prmmd_pkg.sv =====
`timescale 1ns / 1ps

package prmmd_pkg;

  // fixed width of the distance fields
  localparam int OUT_BITS = 37;

  // lane numbering inside the root chain
  localparam int LANE_MIN = 0;
  localparam int LANE_MAX = 1;
  localparam int LANES    = 2;

  // bits of the integer root of (dx^2 + dy^2) << 2*frac_bits
  function automatic int root_bits(input int coord_bits, input int frac_bits);
    root_bits = coord_bits + frac_bits + 1;
  endfunction

endpackage

// ===== hdl/point_rect_min_max_distance.sv =====
`timescale 1ns / 1ps
// Point to rectangle minimum and maximum distance.
// Input channel in_*: a query point and an axis-aligned rectangle, signed
// coordinates, one transaction per item. Output channel out_*: one
// transaction per item with the distance to the nearest point of the
// rectangle and to its farthest corner, unsigned fixed point with FRAC_BITS
// fraction bits, rounded down (saturated to all ones if it does not fit).
// Both channels move a transaction when valid is high and stall is low.
// Throughput is one transaction per cycle while in_stall is low. Between
// input acceptance and out_valid lie four prep stages (select, difference,
// square, sum), one root cell per result bit in a chain of COORD_BITS +
// FRAC_BITS + 1 cells, and the output register.
// When the receiver stalls, the pipeline keeps moving until one finished
// result sits in the output register and a second in the skid register;
// then in_stall rises and the whole pipeline holds. in_stall is a register.
// Reset (rst_n low at a clock edge) empties the pipeline and drops any
// result not yet taken; there is no other state.
module point_rect_min_max_distance #(
  parameter int COORD_BITS = 28,
  parameter int FRAC_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [COORD_BITS-1:0]       in_query_x,
  input  logic signed [COORD_BITS-1:0]       in_query_y,
  input  logic signed [COORD_BITS-1:0]       in_rect_left,
  input  logic signed [COORD_BITS-1:0]       in_rect_bottom,
  input  logic signed [COORD_BITS-1:0]       in_rect_right,
  input  logic signed [COORD_BITS-1:0]       in_rect_top,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [prmmd_pkg::OUT_BITS-1:0]     out_min_distance,
  output logic [prmmd_pkg::OUT_BITS-1:0]     out_max_distance
);
  import prmmd_pkg::*;

  localparam int RW   = root_bits(COORD_BITS, FRAC_BITS);
  localparam int RADW = 2 * RW;

  logic adv;

  logic            prep_valid;
  logic [RADW-1:0] prep_rad_min, prep_rad_max;

  logic                  chain_valid [RW+1];
  logic [1:0][RADW-1:0]  chain_rad   [RW+1];
  logic [1:0][RW+1:0]    chain_rem   [RW+1];
  logic [1:0][RW-1:0]    chain_root  [RW+1];

  logic [OUT_BITS-1:0] res_min, res_max;
  logic                push, out_load;

  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  logic [OUT_BITS-1:0] out_min_r, out_min_nxt, out_max_r, out_max_nxt;
  logic [OUT_BITS-1:0] skid_min_r, skid_min_nxt, skid_max_r, skid_max_nxt;

  // pipeline moves whenever the skid register is free
  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  prmmd_prep #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .valid_i     (in_valid),
    .query_x     (in_query_x),
    .query_y     (in_query_y),
    .rect_left   (in_rect_left),
    .rect_bottom (in_rect_bottom),
    .rect_right  (in_rect_right),
    .rect_top    (in_rect_top),
    .valid_o     (prep_valid),
    .rad_min_o   (prep_rad_min),
    .rad_max_o   (prep_rad_max)
  );

  // head of the root chain
  assign chain_valid[0]          = prep_valid;
  assign chain_rad[0][LANE_MIN]  = prep_rad_min;
  assign chain_rad[0][LANE_MAX]  = prep_rad_max;
  assign chain_rem[0]            = '0;
  assign chain_root[0]           = '0;

  // one cell per root bit
  for (genvar i = 0; i < RW; i++) begin : g_cell
    prmmd_cell #(
      .W (RW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (chain_valid[i]),
      .rad_i   (chain_rad[i]),
      .rem_i   (chain_rem[i]),
      .root_i  (chain_root[i]),
      .valid_o (chain_valid[i+1]),
      .rad_o   (chain_rad[i+1]),
      .rem_o   (chain_rem[i+1]),
      .root_o  (chain_root[i+1])
    );
  end

  // saturate roots wider than the result field
  if (RW > OUT_BITS) begin : g_sat
    assign res_min = (|chain_root[RW][LANE_MIN][RW-1:OUT_BITS]) ?
                     '1 : chain_root[RW][LANE_MIN][OUT_BITS-1:0];
    assign res_max = (|chain_root[RW][LANE_MAX][RW-1:OUT_BITS]) ?
                     '1 : chain_root[RW][LANE_MAX][OUT_BITS-1:0];
  end else begin : g_ext
    assign res_min = OUT_BITS'(chain_root[RW][LANE_MIN]);
    assign res_max = OUT_BITS'(chain_root[RW][LANE_MAX]);
  end

  assign push     = adv && chain_valid[RW];
  assign out_load = !out_valid_r || !out_stall;

  // output register with skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;
    skid_min_nxt   = skid_min_r;
    skid_max_nxt   = skid_max_r;
    if (out_load) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_min_nxt    = skid_min_r;
        out_max_nxt    = skid_max_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_min_nxt   = res_min;
        out_max_nxt   = res_max;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_min_nxt   = res_min;
      skid_max_nxt   = res_max;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_min_r  <= out_min_nxt;
    out_max_r  <= out_max_nxt;
    skid_min_r <= skid_min_nxt;
    skid_max_r <= skid_max_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_min_distance = out_min_r;
  assign out_max_distance = out_max_r;

endmodule

// ===== hdl/prmmd_prep.sv =====
`timescale 1ns / 1ps

module prmmd_prep #(
  parameter int COORD_BITS = 28,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] rect_left,
  input  logic signed [COORD_BITS-1:0] rect_bottom,
  input  logic signed [COORD_BITS-1:0] rect_right,
  input  logic signed [COORD_BITS-1:0] rect_top,
  output logic                         valid_o,
  output logic [2*(COORD_BITS+FRAC_BITS+1)-1:0] rad_min_o,
  output logic [2*(COORD_BITS+FRAC_BITS+1)-1:0] rad_max_o
);
  import prmmd_pkg::*;

  localparam int RW   = root_bits(COORD_BITS, FRAC_BITS);
  localparam int RADW = 2 * RW;
  localparam int SQW  = 2 * COORD_BITS;
  localparam int SUMW = SQW + 1;

  // absolute difference of two coordinates, always below 2^COORD_BITS
  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
  endfunction

  // nearest coordinate on an interval, inverted intervals handled as given
  function automatic logic signed [COORD_BITS-1:0] nearest_on(
    input logic signed [COORD_BITS-1:0] q,
    input logic signed [COORD_BITS-1:0] lo,
    input logic signed [COORD_BITS-1:0] hi
  );
    if (q >= lo && q <= hi) begin
      nearest_on = q;
    end else if (q > hi) begin
      nearest_on = hi;
    end else begin
      nearest_on = lo;
    end
  endfunction

  // far edge by midpoint test 2*q < lo + hi
  function automatic logic signed [COORD_BITS-1:0] farthest_of(
    input logic signed [COORD_BITS-1:0] q,
    input logic signed [COORD_BITS-1:0] lo,
    input logic signed [COORD_BITS-1:0] hi
  );
    logic signed [COORD_BITS+1:0] twice_q;
    logic signed [COORD_BITS+1:0] edge_sum;
    twice_q  = {q[COORD_BITS-1], q, 1'b0};
    edge_sum = {{2{lo[COORD_BITS-1]}}, lo} + {{2{hi[COORD_BITS-1]}}, hi};
    farthest_of = (twice_q < edge_sum) ? hi : lo;
  endfunction

  logic [3:0] valid_r;

  logic signed [COORD_BITS-1:0] qx_r, qy_r, nx_r, ny_r, fx_r, fy_r;
  logic [COORD_BITS-1:0]        dnx_r, dny_r, dfx_r, dfy_r;
  logic [SQW-1:0]               snx_r, sny_r, sfx_r, sfy_r;
  logic [RADW-1:0]              rad_min_r, rad_max_r;
  logic [SUMW-1:0]              sum_min, sum_max;

  // valid bits follow the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[2:0], valid_i};
    end
  end

  assign sum_min = SUMW'(snx_r) + SUMW'(sny_r);
  assign sum_max = SUMW'(sfx_r) + SUMW'(sfy_r);

  // stage 1: pick nearest and farthest coordinates
  // stage 2: absolute differences
  // stage 3: squares
  // stage 4: sum and scale to the fixed point radicand
  always_ff @(posedge clk) begin
    if (adv) begin
      qx_r <= query_x;
      qy_r <= query_y;
      nx_r <= nearest_on(query_x, rect_left, rect_right);
      ny_r <= nearest_on(query_y, rect_bottom, rect_top);
      fx_r <= farthest_of(query_x, rect_left, rect_right);
      fy_r <= farthest_of(query_y, rect_bottom, rect_top);

      dnx_r <= abs_diff(nx_r, qx_r);
      dny_r <= abs_diff(ny_r, qy_r);
      dfx_r <= abs_diff(fx_r, qx_r);
      dfy_r <= abs_diff(fy_r, qy_r);

      snx_r <= SQW'(dnx_r) * SQW'(dnx_r);
      sny_r <= SQW'(dny_r) * SQW'(dny_r);
      sfx_r <= SQW'(dfx_r) * SQW'(dfx_r);
      sfy_r <= SQW'(dfy_r) * SQW'(dfy_r);

      rad_min_r <= RADW'(sum_min) << (2 * FRAC_BITS);
      rad_max_r <= RADW'(sum_max) << (2 * FRAC_BITS);
    end
  end

  assign valid_o   = valid_r[3];
  assign rad_min_o = rad_min_r;
  assign rad_max_o = rad_max_r;

endmodule

// ===== hdl/prmmd_cell.sv =====
`timescale 1ns / 1ps

module prmmd_cell #(
  parameter int W = 37
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  valid_i,
  input  logic [1:0][2*W-1:0]   rad_i,
  input  logic [1:0][W+1:0]     rem_i,
  input  logic [1:0][W-1:0]     root_i,
  output logic                  valid_o,
  output logic [1:0][2*W-1:0]   rad_o,
  output logic [1:0][W+1:0]     rem_o,
  output logic [1:0][W-1:0]     root_o
);
  import prmmd_pkg::*;

  logic                  valid_r;
  logic [1:0][2*W-1:0]   rad_r,  rad_nxt;
  logic [1:0][W+1:0]     rem_r,  rem_nxt;
  logic [1:0][W-1:0]     root_r, root_nxt;

  // one restoring root digit per lane
  always_comb begin
    logic [W+1:0] cur;
    logic [W+1:0] trial;
    rad_nxt  = '0;
    rem_nxt  = '0;
    root_nxt = '0;
    cur      = '0;
    trial    = '0;
    for (int l = 0; l < LANES; l++) begin
      cur   = {rem_i[l][W-1:0], rad_i[l][2*W-1:2*W-2]};
      trial = {root_i[l], 2'b01};
      rad_nxt[l] = {rad_i[l][2*W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_nxt[l]  = cur - trial;
        root_nxt[l] = {root_i[l][W-2:0], 1'b1};
      end else begin
        rem_nxt[l]  = cur;
        root_nxt[l] = {root_i[l][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;

endmodule
